@@ rtl/all_pairs_shortest_path_top_macros.svh @@
// Assertion macros used by the checker file.
// Both sample on the rising edge of clk and stand down while rst_n is low.
`ifndef ALL_PAIRS_SHORTEST_PATH_TOP_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_TOP_MACROS_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsp check failed: same-cycle implication");

// Next-cycle implication.
`define APSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsp check failed: next-cycle implication");

`endif

@@ rtl/apsp_pkg.sv @@
`timescale 1ns / 1ps

package apsp_pkg;

    localparam int VTX_W    = 6;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 24;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic take;
        logic decode;
        logic copy_step;
        logic fw_init;
        logic row_read;
        logic row_load;
        logic relax;
        logic row_next;
        logic query_rd;
        logic query_load;
        logic load_out;
    } apsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic need_mem;
        logic stale;
        logic ik_absent;
        logic j_last;
        logic last_row;
        logic out_free;
    } apsp_status_t;

endpackage

@@ rtl/apsp_ram.sv @@
`timescale 1ns / 1ps

module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ rtl/apsp_ctrl.sv @@
`timescale 1ns / 1ps

module apsp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  apsp_pkg::apsp_status_t status,
    output apsp_pkg::apsp_cmd_t    cmd,
    output logic                  ready
);

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_DECODE     = 4'd2;
    localparam logic [3:0] S_COPY       = 4'd3;
    localparam logic [3:0] S_COPY_TAIL  = 4'd4;
    localparam logic [3:0] S_ROW_START  = 4'd5;
    localparam logic [3:0] S_ROW_LOAD   = 4'd6;
    localparam logic [3:0] S_RELAX      = 4'd7;
    localparam logic [3:0] S_QUERY_RD   = 4'd8;
    localparam logic [3:0] S_QUERY_LOAD = 4'd9;
    localparam logic [3:0] S_RESULT     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (!status.need_mem)
                begin
                    state_next = S_RESULT;
                end
                else if (status.stale)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_QUERY_RD;
                end
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_COPY_TAIL;
                end
            end
            S_COPY_TAIL:
            begin
                // last copied entry lands in this cycle
                cmd.fw_init = 1'b1;
                state_next  = S_ROW_START;
            end
            S_ROW_START:
            begin
                cmd.row_read = 1'b1;
                state_next   = S_ROW_LOAD;
            end
            S_ROW_LOAD:
            begin
                cmd.row_load = 1'b1;
                if (status.ik_absent)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = status.last_row ? S_QUERY_RD : S_ROW_START;
                end
                else
                begin
                    state_next = S_RELAX;
                end
            end
            S_RELAX:
            begin
                cmd.relax = 1'b1;
                if (status.j_last)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = status.last_row ? S_QUERY_RD : S_ROW_START;
                end
            end
            S_QUERY_RD:
            begin
                cmd.query_rd = 1'b1;
                state_next   = S_QUERY_LOAD;
            end
            S_QUERY_LOAD:
            begin
                cmd.query_load = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/apsp_datapath.sv @@
`timescale 1ns / 1ps

module apsp_datapath #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  apsp_pkg::apsp_cmd_t                    cmd,
    output apsp_pkg::apsp_status_t                 status,
    input  logic [apsp_pkg::OP_W-1:0]              opcode,
    input  logic [apsp_pkg::VTX_W-1:0]             src_vertex,
    input  logic [apsp_pkg::VTX_W-1:0]             dst_vertex,
    input  logic signed [apsp_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic                                   path_found,
    output logic signed [apsp_pkg::DIST_W-1:0]     distance
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int AW     = 2 * VW;
    localparam int DEPTH  = 1 << AW;
    localparam int CNTW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW   = (CNTW > apsp_pkg::VTX_W + 1) ? CNTW : apsp_pkg::VTX_W + 1;
    localparam int EDGE_W = apsp_pkg::WEIGHT_W + 1;
    localparam int DENT_W = apsp_pkg::DIST_W + 1;
    localparam int DW     = apsp_pkg::DIST_W;

    logic [apsp_pkg::OP_W-1:0]            op_reg;
    logic [apsp_pkg::VTX_W-1:0]           src_reg;
    logic [apsp_pkg::VTX_W-1:0]           dst_reg;
    logic signed [apsp_pkg::WEIGHT_W-1:0] wgt_reg;
    logic [CNTW-1:0]                      count_reg;
    logic                                 stale_reg;
    logic [AW-1:0]                        sweep_reg;
    logic                                 copy_wr_reg;
    logic [AW-1:0]                        copy_addr_reg;
    logic [VW-1:0]                        k_reg;
    logic [VW-1:0]                        i_reg;
    logic [VW-1:0]                        j_reg;
    logic signed [DW-1:0]                 dik_reg;
    logic                                 res_found_reg;
    logic signed [DW-1:0]                 res_dist_reg;
    logic                                 out_valid_reg;
    logic                                 out_found_reg;
    logic signed [DW-1:0]                 out_dist_reg;

    logic [CMPW-1:0] src_c;
    logic [CMPW-1:0] dst_c;
    logic [CMPW-1:0] cnt_c;
    logic [CMPW-1:0] top_c;
    logic            in_bound;
    logic            in_range;
    logic            same_vtx;
    logic            add_ok;
    logic            rem_ok;
    logic [AW-1:0]   pair_addr;
    logic [VW-1:0]   n1;
    logic [VW-1:0]   j_inc;

    logic                 edge_wr_en;
    logic [AW-1:0]        edge_wr_addr;
    logic [EDGE_W-1:0]    edge_wr_data;
    logic [EDGE_W-1:0]    edge_rd;
    logic signed [apsp_pkg::WEIGHT_W-1:0] edge_wgt;

    logic                 dist_wr_en;
    logic [AW-1:0]        dist_wr_addr;
    logic [DENT_W-1:0]    dist_wr_data;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [DENT_W-1:0]    rda;
    logic [DENT_W-1:0]    rdb;

    logic                 kj_valid;
    logic                 ij_valid;
    logic signed [DW-1:0] kj_dist;
    logic signed [DW-1:0] ij_dist;
    logic signed [DW:0]   sum;
    logic signed [DW-1:0] cand;
    logic                 relax_wr;

    assign src_c    = CMPW'(src_reg);
    assign dst_c    = CMPW'(dst_reg);
    assign cnt_c    = CMPW'(count_reg);
    assign top_c    = ((src_c > dst_c) ? src_c : dst_c) + 1'b1;
    assign in_bound = (src_c < CMPW'(MAX_VERTICES)) && (dst_c < CMPW'(MAX_VERTICES));
    assign in_range = (src_c < cnt_c) && (dst_c < cnt_c);
    assign same_vtx = (src_reg == dst_reg);
    assign add_ok   = (op_reg == apsp_pkg::OP_ADD) && in_bound;
    assign rem_ok   = (op_reg == apsp_pkg::OP_REMOVE) && in_range && !same_vtx;
    assign pair_addr = {VW'(src_reg), VW'(dst_reg)};
    assign n1       = VW'(count_reg - 1'b1);
    assign j_inc    = j_reg + 1'b1;

    // Edge matrix: cleared after reset, written by add/remove, swept by the copy.
    assign edge_wr_en   = cmd.clr_step || (cmd.decode && (add_ok || rem_ok));
    assign edge_wr_addr = cmd.clr_step ? sweep_reg : pair_addr;
    always_comb
    begin
        edge_wr_data = '0;
        if (!cmd.clr_step && add_ok)
        begin
            edge_wr_data = {1'b1, same_vtx ? {apsp_pkg::WEIGHT_W{1'b0}} : wgt_reg};
        end
    end

    apsp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (DEPTH)
    ) u_edge_ram (
        .clk       (clk),
        .wr_en     (edge_wr_en),
        .wr_addr   (edge_wr_addr),
        .wr_data   (edge_wr_data),
        .rd_addr_a (sweep_reg),
        .rd_data_a (edge_rd),
        .rd_addr_b (sweep_reg),
        .rd_data_b ()
    );

    assign edge_wgt = signed'(edge_rd[apsp_pkg::WEIGHT_W-1:0]);

    // Relaxation: port A carries d[k][j], port B d[i][j].
    assign kj_valid = rda[DW];
    assign kj_dist  = signed'(rda[DW-1:0]);
    assign ij_valid = rdb[DW];
    assign ij_dist  = signed'(rdb[DW-1:0]);
    assign sum      = {dik_reg[DW-1], dik_reg} + {kj_dist[DW-1], kj_dist};
    always_comb
    begin
        if (sum[DW] != sum[DW-1])
        begin
            cand = sum[DW] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
        end
        else
        begin
            cand = sum[DW-1:0];
        end
    end
    assign relax_wr = cmd.relax && kj_valid && (!ij_valid || (cand < ij_dist));

    assign dist_wr_en   = copy_wr_reg || relax_wr;
    assign dist_wr_addr = copy_wr_reg ? copy_addr_reg : {i_reg, j_reg};
    assign dist_wr_data = copy_wr_reg ? {edge_rd[apsp_pkg::WEIGHT_W], DW'(edge_wgt)}
                                      : {1'b1, cand};

    always_comb
    begin
        if (cmd.row_read)
        begin
            rd_addr_a = {i_reg, k_reg};
        end
        else if (cmd.query_rd)
        begin
            rd_addr_a = pair_addr;
        end
        else if (cmd.row_load)
        begin
            rd_addr_a = {k_reg, {VW{1'b0}}};
        end
        else
        begin
            rd_addr_a = {k_reg, j_inc};
        end
    end
    assign rd_addr_b = cmd.row_load ? {i_reg, {VW{1'b0}}} : {i_reg, j_inc};

    apsp_ram #(
        .WIDTH (DENT_W),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .clk       (clk),
        .wr_en     (dist_wr_en),
        .wr_addr   (dist_wr_addr),
        .wr_data   (dist_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rda),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rdb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            stale_reg     <= 1'b1;
            sweep_reg     <= '0;
            copy_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            copy_wr_reg <= cmd.copy_step;
            if (cmd.clr_step || cmd.copy_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.decode && add_ok)
            begin
                if (top_c > cnt_c)
                begin
                    count_reg <= CNTW'(top_c);
                end
                if (!same_vtx)
                begin
                    stale_reg <= 1'b1;
                end
            end
            if (cmd.decode && rem_ok)
            begin
                stale_reg <= 1'b1;
            end
            if (cmd.query_rd)
            begin
                stale_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= opcode;
            src_reg <= src_vertex;
            dst_reg <= dst_vertex;
            wgt_reg <= edge_weight;
        end
        if (cmd.copy_step)
        begin
            copy_addr_reg <= sweep_reg;
        end
        if (cmd.fw_init)
        begin
            k_reg <= '0;
            i_reg <= '0;
        end
        if (cmd.row_next)
        begin
            if (i_reg == n1)
            begin
                i_reg <= '0;
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
        if (cmd.row_load)
        begin
            j_reg   <= '0;
            dik_reg <= signed'(rda[DW-1:0]);
        end
        if (cmd.relax)
        begin
            j_reg <= j_inc;
            // d[i][k] moves when the row passes column k
            if (relax_wr && (j_reg == k_reg))
            begin
                dik_reg <= cand;
            end
        end
        if (cmd.decode)
        begin
            res_found_reg <= (op_reg == apsp_pkg::OP_QUERY) && in_range && same_vtx;
            res_dist_reg  <= '0;
        end
        if (cmd.query_load)
        begin
            res_found_reg <= rda[DW];
            res_dist_reg  <= rda[DW] ? signed'(rda[DW-1:0]) : '0;
        end
        if (cmd.load_out)
        begin
            out_found_reg <= res_found_reg;
            out_dist_reg  <= res_dist_reg;
        end
    end

    assign status.sweep_last = &sweep_reg;
    assign status.need_mem   = (op_reg == apsp_pkg::OP_QUERY) && in_range && !same_vtx;
    assign status.stale      = stale_reg;
    assign status.ik_absent  = !rda[DW];
    assign status.j_last     = (j_reg == n1);
    assign status.last_row   = (i_reg == n1) && (k_reg == n1);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign path_found = out_found_reg;
    assign distance   = out_dist_reg;

endmodule

@@ rtl/all_pairs_shortest_path_top.sv @@
// Add, remove and queries answered without a rerun need no sweep: a stored distance is
// read once from the distance matrix. A query after an edge change first copies the edge
// matrix, then relaxes one (k,i,j) triple a cycle for the n vertices in use.
// One item at a time; the next is taken once the previous result sits in the output register.
// After reset the whole edge matrix is cleared before s_axis_tready first rises.
`timescale 1ns / 1ps

module all_pairs_shortest_path_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // src_vertex[5:0], dst_vertex[11:6], edge_weight[27:12]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // distance[23:0]
    output logic        m_axis_tuser   // path_found
);

    apsp_pkg::apsp_cmd_t    cmd;
    apsp_pkg::apsp_status_t status;
    logic signed [apsp_pkg::DIST_W-1:0] distance;

    apsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .status     (status),
        .cmd        (cmd),
        .ready      (s_axis_tready)
    );

    apsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (s_axis_tuser),
        .src_vertex  (s_axis_tdata[5:0]),
        .dst_vertex  (s_axis_tdata[11:6]),
        .edge_weight (signed'(s_axis_tdata[27:12])),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .path_found  (m_axis_tuser),
        .distance    (distance)
    );

    assign m_axis_tdata = distance;

endmodule

@@ rtl/apsp_checker.sv @@
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_top_macros.svh"

module apsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a pending result stays offered
    `APSP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // a result without a path carries zero distance
    `APSP_ASSERT_IMP(a_no_path_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0)
    // one item in flight: input closes after each transaction
    `APSP_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a stalled result keeps its payload
    `APSP_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
                     $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind all_pairs_shortest_path_top apsp_checker u_apsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
